// ----- sv/sacl_pkg.sv -----
// Package: payload types, config indexes and sequencer states for the LRU tag model.
package sacl_pkg;

   typedef struct packed {
      logic        action;
      logic [63:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        eviction;
      logic        dirty_writeback;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
      logic [63:0] dirty_resident_bytes;
      logic [63:0] dirty_evicted_bytes;
   } rsp_type;

   localparam int CSR_DATA_W = 6;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   localparam logic ACT_STORE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_RESP
   } state_type;

endpackage

// ----- sv/set_assoc_cache_lru_tag_model.sv -----
// Top level: set-associative LRU tag model with one set-wide line memory.
//
// Each request takes the set's line state from one synchronous memory that holds
// a whole set (all ways: valid, dirty, rank, tag) per entry. A request is accepted
// in IDLE, the set is read into a register as the request is accepted, compared
// and updated in LOOKUP, and the response is held in RESP until taken; the next
// request is accepted in the cycle the response leaves. After reset a clearing
// pass writes every set once, during which no request is accepted.
module set_assoc_cache_lru_tag_model #(
   parameter int MAX_SET_INDEX_BITS = 6,
   parameter int MAX_WAYS           = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sacl_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sacl_pkg::rsp_type            rsp_data,
   input  logic                         csr_write,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sacl_pkg::*;

   localparam int SETS   = 1 << MAX_SET_INDEX_BITS;
   localparam int SET_W  = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1;
   localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W  = $clog2(MAX_WAYS + 1);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
      logic [63:0]       tag;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] set_line_type;

   // Configuration registers
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd4;
         block_bits_ff <= 6'd4;
         ways_ff       <= 4'd8;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[5:0];
            CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Effective configuration
   logic [3:0]       sbits;
   logic [CNT_W-1:0] ways_eff;
   logic [6:0]       tshift;
   logic [63:0]      bytes;

   always_comb begin
      if ({1'b0, set_bits_ff} > 4'(MAX_SET_INDEX_BITS)) sbits = 4'(MAX_SET_INDEX_BITS);
      else sbits = {1'b0, set_bits_ff};
      if (ways_ff == 4'd0) ways_eff = CNT_W'(1);
      else if (5'(ways_ff) > 5'(MAX_WAYS)) ways_eff = CNT_W'(MAX_WAYS);
      else ways_eff = CNT_W'(ways_ff);
      tshift = 7'(sbits) + 7'(block_bits_ff);
      bytes  = 64'd1 << block_bits_ff;
   end

   // Sequencer state and request registers
   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [SET_W-1:0]  set_ff;
   logic [63:0]       tag_ff;
   logic [SET_W-1:0]  clr_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [31:0]       hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic [63:0]       dirty_sum_ff, wb_sum_ff;

   // Set-wide line memory
   set_line_type mem [SETS];
   set_line_type rd_ff;
   logic         wr_en;
   logic [SET_W-1:0] wr_addr;
   set_line_type wr_data;
   set_line_type upd;

   logic [SET_W-1:0] rd_addr;
   logic [63:0]      shifted;

   always_comb begin
      shifted = req_data.address >> block_bits_ff;
      rd_addr = SET_W'(shifted & ((64'd1 << sbits) - 64'd1));
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   // Lookup: compare, pick the way, update ranks
   logic             hit, found, evict, wb;
   logic [WAY_W-1:0] hway, iway, vway, way;
   logic [RANK_W-1:0] old_rank;
   logic             was_valid;

   always_comb begin
      hit = 1'b0; found = 1'b0; hway = '0; iway = '0; vway = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (CNT_W'(i) < ways_eff) begin
            if (rd_ff[i].valid && rd_ff[i].tag == tag_ff) begin
               hit = 1'b1; hway = WAY_W'(i);
            end
            if (!rd_ff[i].valid) begin
               found = 1'b1; iway = WAY_W'(i);
            end
         end
      end
      // highest rank, lowest way on tie
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (CNT_W'(i) < ways_eff && rd_ff[i].rank > rd_ff[vway].rank) vway = WAY_W'(i);
      end
      if (hit) way = hway;
      else if (found) way = iway;
      else way = vway;
      evict     = !hit && !found;
      wb        = evict && rd_ff[way].dirty;
      was_valid = hit || evict;
      old_rank  = rd_ff[way].rank;

      upd = rd_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (CNT_W'(i) < ways_eff && WAY_W'(i) != way && rd_ff[i].valid &&
             (!was_valid || rd_ff[i].rank < old_rank) && rd_ff[i].rank < RANK_MAX)
            upd[i].rank = rd_ff[i].rank + RANK_W'(1);
      end
      upd[way].rank  = '0;
      upd[way].valid = 1'b1;
      upd[way].tag   = tag_ff;
      if (hit) upd[way].dirty = rd_ff[way].dirty || (req_ff.action == ACT_STORE);
      else upd[way].dirty = (req_ff.action == ACT_STORE);
   end

   // Next state, memory write and response
   logic [31:0] hit_n, miss_n, evict_n;
   logic [63:0] dsum_n, wsum_n;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = set_ff;
      wr_data   = upd;
      rsp_in    = rsp_ff;
      hit_n = hit_cnt_ff; miss_n = miss_cnt_ff; evict_n = evict_cnt_ff;
      dsum_n = dirty_sum_ff; wsum_n = wb_sum_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == SET_W'(SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            wr_en = 1'b1;
            if (hit) begin
               hit_n = hit_cnt_ff + 32'd1;
               if (req_ff.action == ACT_STORE && !rd_ff[way].dirty)
                  dsum_n = dirty_sum_ff + bytes;
            end else begin
               miss_n = miss_cnt_ff + 32'd1;
               if (evict) evict_n = evict_cnt_ff + 32'd1;
               if (wb) begin
                  wsum_n = wb_sum_ff + bytes;
                  dsum_n = dirty_sum_ff - bytes;
               end
               if (req_ff.action == ACT_STORE) dsum_n = dsum_n + bytes;
            end
            rsp_in.hit                  = hit;
            rsp_in.eviction             = evict;
            rsp_in.dirty_writeback      = wb;
            rsp_in.hit_total            = hit_n;
            rsp_in.miss_total           = miss_n;
            rsp_in.eviction_total       = evict_n;
            rsp_in.dirty_resident_bytes = dsum_n;
            rsp_in.dirty_evicted_bytes  = wsum_n;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               req_ready = 1'b1;
               state_in  = req_valid ? ST_LOOKUP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         dirty_sum_ff <= '0;
         wb_sum_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_ff + SET_W'(1);
         hit_cnt_ff   <= hit_n;
         miss_cnt_ff  <= miss_n;
         evict_cnt_ff <= evict_n;
         dirty_sum_ff <= dsum_n;
         wb_sum_ff    <= wsum_n;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         req_ff <= req_data;
         set_ff <= rd_addr;
         tag_ff <= (tshift >= 7'd64) ? 64'd0 : (req_data.address >> tshift);
      end
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   // Checks
   a_one_way_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && hit) |-> !evict && !wb)
      else $error("hit with eviction");
   a_wb_needs_evict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && wb) |-> evict)
      else $error("writeback without eviction");
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during clear");
   a_resp_follows_lookup: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == ST_LOOKUP) && !$past(reset) |-> rsp_valid)
      else $error("lookup not followed by response");
endmodule
